@@ rtl/wmot_pkg.sv @@
`timescale 1ns / 1ps
// wmot_pkg: shared types and constants for the windowed momentum order trigger
// used by windowed_momentum_order_trigger, wmot_order_checker and the testbench; no dependencies

package wmot_pkg;

  // default sizing, handed down as top level parameters
  localparam int WINDOW_MAX_DEF = 64;
  localparam int PRICE_BITS_DEF = 32;

  // fixed field widths
  localparam int LOOKBACK_W = 7;
  localparam int WORD_W     = 32;
  localparam int ID_W       = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int ID_BASE_W  = 30;

  // order ids start at client_id times this, plus one
  localparam logic [ID_BASE_W-1:0] ID_BASE = 30'd1_000_000_000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOKBACK_LEN     = 3'd0,
    CFG_MOVE_THRESHOLD   = 3'd1,
    CFG_TRADE_ORDER_SIZE = 3'd2,
    CFG_PROBE_PERIOD     = 3'd3,
    CFG_PROBE_ORDER_SIZE = 3'd4,
    CFG_CLIENT_ID        = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    CMD_TRADE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef enum logic {
    SIDE_BUY  = 1'b0,
    SIDE_SELL = 1'b1
  } side_t;

  typedef enum logic {
    KIND_MOMENTUM = 1'b0,
    KIND_PROBE    = 1'b1
  } kind_t;

endpackage

@@ rtl/windowed_momentum_order_trigger.sv @@
`timescale 1ns / 1ps
// windowed_momentum_order_trigger: momentum and probe order generator, top level
// uses wmot_pkg and wmot_ring
//
//   channel | signals                                       | transfer when
//   --------+-----------------------------------------------+---------------------
//   input   | in_valid, in_stall, cmd, price                | in_valid & !in_stall
//   output  | out_valid, out_stall, order_side/qty/id/kind  | out_valid & !out_stall
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data     | cfg_valid & cfg_ready
//
// one item per cycle sustained while in_stall is low; an order passes the middle stage and the
// ring read port (both loaded when its item is taken), then the output register
// the middle stage holds while the output register is stalled; cfg_ready is always high
// rst (synchronous) clears control state; the ring needs no clearing pass
// in_stall rises only when the middle stage is full and the output register is held

module windowed_momentum_order_trigger #(
  parameter int WINDOW_MAX = wmot_pkg::WINDOW_MAX_DEF,
  parameter int PRICE_BITS = wmot_pkg::PRICE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           cmd,
  input  logic [wmot_pkg::WORD_W-1:0]    price,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           order_side,
  output logic [wmot_pkg::WORD_W-1:0]    order_qty,
  output logic [wmot_pkg::ID_W-1:0]      order_id,
  output logic                           order_kind,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wmot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmot_pkg::WORD_W-1:0]    cfg_data
);

  localparam int PTR_W  = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int LEN_W  = (CNT_W > wmot_pkg::LOOKBACK_W) ? CNT_W : wmot_pkg::LOOKBACK_W;
  localparam int DIFF_W = (PRICE_BITS > wmot_pkg::WORD_W) ? PRICE_BITS : wmot_pkg::WORD_W;
  localparam int PROD_W = wmot_pkg::WORD_W + wmot_pkg::ID_BASE_W;

  // configuration registers
  logic [wmot_pkg::LOOKBACK_W-1:0] lookback_len;
  logic [wmot_pkg::WORD_W-1:0]     move_threshold;
  logic [wmot_pkg::WORD_W-1:0]     trade_order_size;
  logic [wmot_pkg::WORD_W-1:0]     probe_period;
  logic [wmot_pkg::WORD_W-1:0]     probe_order_size;

  // state
  logic [PTR_W-1:0]            write_pointer;
  logic [CNT_W-1:0]            fill_count;
  logic [wmot_pkg::ID_W-1:0]   next_id;
  logic [wmot_pkg::WORD_W-1:0] tick_phase;
  logic                        probe_is_buy;

  // middle stage
  logic                  s1_valid;
  logic                  s1_kind;
  logic                  s1_side;
  logic                  s1_check;
  logic                  s1_same;
  logic [PRICE_BITS-1:0] s1_newest;
  logic [PRICE_BITS-1:0] ring_rd_data;

  logic                  in_xfer;
  logic                  cfg_xfer;
  logic                  is_trade;
  logic                  is_tick;
  logic [63:0]           price_ext;
  logic [PRICE_BITS-1:0] p;
  logic [CNT_W-1:0]      len_eff;
  logic [CNT_W-1:0]      len_m1;
  logic [CNT_W-1:0]      fill_inc;
  logic [CNT_W-1:0]      fill_count_next;
  logic [PTR_W-1:0]      write_pointer_next;
  logic [PTR_W-1:0]      rd_addr;
  logic [CNT_W-1:0]      rd_addr_wide;
  logic [CNT_W-1:0]      wp_wide;
  logic [wmot_pkg::WORD_W-1:0] tick_phase_inc;
  logic                  probe_fire;
  logic                  s1_adv;
  logic                  s1_order;
  logic                  s1_fire;
  logic                  rise;
  logic                  fall;
  logic [PRICE_BITS-1:0] oldest;
  logic [DIFF_W-1:0]     up_move;
  logic [DIFF_W-1:0]     down_move;
  logic [DIFF_W-1:0]     thr_ext;
  logic [PROD_W-1:0]     id_prod;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid & cfg_ready;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;
  assign is_trade = in_xfer && (cmd == wmot_pkg::CMD_TRADE);
  assign is_tick  = in_xfer && (cmd == wmot_pkg::CMD_TICK);

  assign price_ext = 64'(price);
  assign p         = price_ext[PRICE_BITS-1:0];

  // window length, clamped to the ring size
  always_comb begin
    if (LEN_W'(lookback_len) > LEN_W'(WINDOW_MAX)) begin
      len_eff = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff = CNT_W'(lookback_len);
    end
  end

  assign len_m1   = len_eff - CNT_W'(1);
  assign fill_inc = fill_count + CNT_W'(1);
  assign fill_count_next = (fill_inc > len_eff) ? len_eff : fill_inc;

  assign write_pointer_next = (write_pointer == PTR_W'(WINDOW_MAX - 1)) ? '0
                            : write_pointer + PTR_W'(1);

  // oldest slot of the window, modulo the ring size
  assign wp_wide = CNT_W'(write_pointer);
  always_comb begin
    if (wp_wide >= len_m1) begin
      rd_addr_wide = wp_wide - len_m1;
    end else begin
      rd_addr_wide = wp_wide + CNT_W'(WINDOW_MAX) - len_m1;
    end
  end
  assign rd_addr = rd_addr_wide[PTR_W-1:0];

  wmot_ring #(
    .DEPTH  (WINDOW_MAX),
    .DATA_W (PRICE_BITS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (is_trade),
    .wr_addr (write_pointer),
    .wr_data (p),
    .rd_en   (in_xfer),
    .rd_addr (rd_addr),
    .rd_data (ring_rd_data)
  );

  assign tick_phase_inc = tick_phase + wmot_pkg::WORD_W'(1);
  assign probe_fire     = (probe_period != '0) && (tick_phase_inc >= probe_period);

  // client id times the id base; always even, so the plus one is a bit set
  assign id_prod = PROD_W'(cfg_data) * PROD_W'(wmot_pkg::ID_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      lookback_len     <= '0;
      move_threshold   <= '0;
      trade_order_size <= '0;
      probe_period     <= '0;
      probe_order_size <= '0;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        wmot_pkg::CFG_LOOKBACK_LEN:     lookback_len     <= cfg_data[wmot_pkg::LOOKBACK_W-1:0];
        wmot_pkg::CFG_MOVE_THRESHOLD:   move_threshold   <= cfg_data;
        wmot_pkg::CFG_TRADE_ORDER_SIZE: trade_order_size <= cfg_data;
        wmot_pkg::CFG_PROBE_PERIOD:     probe_period     <= cfg_data;
        wmot_pkg::CFG_PROBE_ORDER_SIZE: probe_order_size <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      fill_count    <= '0;
      tick_phase    <= '0;
      probe_is_buy  <= 1'b1;
    end else begin
      if (is_trade) begin
        write_pointer <= write_pointer_next;
        fill_count    <= fill_count_next;
      end
      if (cfg_xfer && cfg_index == wmot_pkg::CFG_PROBE_PERIOD) begin
        tick_phase <= '0;
      end else if (is_tick && probe_period != '0) begin
        tick_phase <= probe_fire ? '0 : tick_phase_inc;
        if (probe_fire) begin
          probe_is_buy <= !probe_is_buy;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_id <= wmot_pkg::ID_W'(1);
    end else if (cfg_xfer && cfg_index == wmot_pkg::CFG_CLIENT_ID) begin
      next_id <= wmot_pkg::ID_W'(id_prod) | wmot_pkg::ID_W'(1);
    end else if (s1_fire) begin
      next_id <= next_id + wmot_pkg::ID_W'(1);
    end
  end

  // middle stage: ring read data lines up with these
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_newest <= p;
      s1_same   <= (len_eff == CNT_W'(1));
      if (cmd == wmot_pkg::CMD_TRADE) begin
        s1_kind  <= wmot_pkg::KIND_MOMENTUM;
        s1_check <= (len_eff != '0) && (fill_count_next >= len_eff);
        s1_side  <= wmot_pkg::SIDE_BUY;
      end else begin
        s1_kind  <= wmot_pkg::KIND_PROBE;
        s1_check <= probe_fire;
        s1_side  <= probe_is_buy ? wmot_pkg::SIDE_BUY : wmot_pkg::SIDE_SELL;
      end
    end
  end

  // a one-price window compares the price with itself
  assign oldest    = s1_same ? s1_newest : ring_rd_data;
  assign up_move   = DIFF_W'(s1_newest) - DIFF_W'(oldest);
  assign down_move = DIFF_W'(oldest) - DIFF_W'(s1_newest);
  assign thr_ext   = DIFF_W'(move_threshold);
  assign rise      = (s1_newest > oldest) && (up_move > thr_ext);
  assign fall      = (oldest > s1_newest) && (down_move > thr_ext);

  assign s1_order = s1_check && ((s1_kind == wmot_pkg::KIND_PROBE) || rise || fall);
  assign s1_fire  = s1_valid && s1_adv && s1_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      order_id   <= next_id;
      order_kind <= s1_kind;
      if (s1_kind == wmot_pkg::KIND_PROBE) begin
        order_side <= s1_side;
        order_qty  <= probe_order_size;
      end else begin
        order_side <= rise ? wmot_pkg::SIDE_BUY : wmot_pkg::SIDE_SELL;
        order_qty  <= trade_order_size;
      end
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    write_pointer <= PTR_W'(WINDOW_MAX - 1))
    else $error("ring write pointer out of range");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW_MAX))
    else $error("fill count above ring size");

  a_stall_needs_s1: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled with room in the pipeline");

  a_id_step: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !cfg_xfer) |=> (next_id == $past(next_id) + wmot_pkg::ID_W'(1)))
    else $error("order id did not advance by one");

  a_phase_below_period: assert property (@(posedge clk) disable iff (rst)
    (probe_period != '0) |-> (tick_phase < probe_period))
    else $error("tick phase reached the probe period");

endmodule

@@ rtl/wmot_ring.sv @@
`timescale 1ns / 1ps
// wmot_ring: price ring memory, one write port and one registered read port
// standalone; sized by the top level parameters

module wmot_ring #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read before write when addresses collide; the top never relies on it
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ bench/wmot_order_checker.sv @@
`timescale 1ns / 1ps
// wmot_order_checker: predicts the orders of windowed_momentum_order_trigger from the
// observed input and config transfers, compares every output transfer; uses wmot_pkg

module wmot_order_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           cmd,
  input  logic [wmot_pkg::WORD_W-1:0]    price,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           order_side,
  input  logic [wmot_pkg::WORD_W-1:0]    order_qty,
  input  logic [wmot_pkg::ID_W-1:0]      order_id,
  input  logic                           order_kind,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [wmot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmot_pkg::WORD_W-1:0]    cfg_data,
  output int unsigned                    orders_due,
  output int unsigned                    mismatches
);

  localparam int PTR_W = $clog2(wmot_pkg::WINDOW_MAX_DEF);

  typedef struct {
    wmot_pkg::side_t             side;
    logic [wmot_pkg::WORD_W-1:0] qty;
    logic [wmot_pkg::ID_W-1:0]   id;
    wmot_pkg::kind_t             kind;
  } order_t;

  order_t pending_orders[$];

  logic [wmot_pkg::WORD_W-1:0]     price_ring [0:wmot_pkg::WINDOW_MAX_DEF-1];
  logic [PTR_W-1:0]                ring_wr;
  logic [wmot_pkg::LOOKBACK_W-1:0] ring_fill;
  logic [wmot_pkg::LOOKBACK_W-1:0] lookback;
  logic [wmot_pkg::WORD_W-1:0]     threshold;
  logic [wmot_pkg::WORD_W-1:0]     trade_qty;
  logic [wmot_pkg::WORD_W-1:0]     period;
  logic [wmot_pkg::WORD_W-1:0]     probe_qty;
  logic [wmot_pkg::ID_W-1:0]       next_order_id;
  logic [wmot_pkg::WORD_W-1:0]     ticks_seen;
  logic                            probe_buy_next;
  int unsigned                     err_cnt;

  function automatic logic [wmot_pkg::ID_W-1:0] first_id(
    input logic [wmot_pkg::WORD_W-1:0] cid);
    return wmot_pkg::ID_W'(cid) * wmot_pkg::ID_W'(wmot_pkg::ID_BASE) + wmot_pkg::ID_W'(1);
  endfunction

  task automatic issue_order(input wmot_pkg::side_t side,
                             input logic [wmot_pkg::WORD_W-1:0] qty,
                             input wmot_pkg::kind_t kind);
    order_t fresh;
    fresh.side = side;
    fresh.qty  = qty;
    fresh.id   = next_order_id;
    fresh.kind = kind;
    pending_orders.insert(pending_orders.size(), fresh);
    next_order_id = next_order_id + wmot_pkg::ID_W'(1);
  endtask

  task automatic trigger_on_item(input logic c, input logic [wmot_pkg::WORD_W-1:0] p);
    logic [wmot_pkg::LOOKBACK_W-1:0] len;
    logic [PTR_W-1:0]                wr;
    logic [wmot_pkg::WORD_W-1:0]     oldest;
    len = (lookback > wmot_pkg::LOOKBACK_W'(wmot_pkg::WINDOW_MAX_DEF))
        ? wmot_pkg::LOOKBACK_W'(wmot_pkg::WINDOW_MAX_DEF) : lookback;
    if (c == wmot_pkg::CMD_TRADE) begin
      wr = ring_wr;
      price_ring[wr] = p;
      ring_wr = wr + 1'b1;
      ring_fill = (ring_fill >= len) ? len : ring_fill + 1'b1;
      if (len != 0 && ring_fill >= len) begin
        // oldest of the newest len prices
        oldest = price_ring[wr - PTR_W'(len - 1'b1)];
        if (p > oldest && p - oldest > threshold) begin
          issue_order(wmot_pkg::SIDE_BUY, trade_qty, wmot_pkg::KIND_MOMENTUM);
        end else if (oldest > p && oldest - p > threshold) begin
          issue_order(wmot_pkg::SIDE_SELL, trade_qty, wmot_pkg::KIND_MOMENTUM);
        end
      end
    end else if (period != 0) begin
      ticks_seen = ticks_seen + 1'b1;
      if (ticks_seen >= period) begin
        ticks_seen = '0;
        issue_order(probe_buy_next ? wmot_pkg::SIDE_BUY : wmot_pkg::SIDE_SELL, probe_qty,
                    wmot_pkg::KIND_PROBE);
        probe_buy_next = !probe_buy_next;
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    order_t want;
    if (rst) begin
      pending_orders.delete();
      ring_wr        = '0;
      ring_fill      = '0;
      lookback       = '0;
      threshold      = '0;
      trade_qty      = '0;
      period         = '0;
      probe_qty      = '0;
      next_order_id  = first_id('0);
      ticks_seen     = '0;
      probe_buy_next = 1'b1;
      err_cnt        = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wmot_pkg::CFG_LOOKBACK_LEN:     lookback = cfg_data[wmot_pkg::LOOKBACK_W-1:0];
          wmot_pkg::CFG_MOVE_THRESHOLD:   threshold = cfg_data;
          wmot_pkg::CFG_TRADE_ORDER_SIZE: trade_qty = cfg_data;
          wmot_pkg::CFG_PROBE_PERIOD: begin
            period = cfg_data;
            ticks_seen = '0;
          end
          wmot_pkg::CFG_PROBE_ORDER_SIZE: probe_qty = cfg_data;
          wmot_pkg::CFG_CLIENT_ID:        next_order_id = first_id(cfg_data);
          default: ;
        endcase
      end
      // an order never leaves in the cycle its item is taken, so compare first
      if (out_valid && !out_stall) begin
        if (pending_orders.size() == 0) begin
          $error("order transfer with no order pending: id %0d", order_id);
          err_cnt++;
        end else begin
          want = pending_orders[0];
          pending_orders.delete(0);
          if (order_side !== want.side) begin
            $error("order_side: expected %0d, got %0d", want.side, order_side);
            err_cnt++;
          end
          if (order_qty !== want.qty) begin
            $error("order_qty: expected %0d, got %0d", want.qty, order_qty);
            err_cnt++;
          end
          if (order_id !== want.id) begin
            $error("order_id: expected %0d, got %0d", want.id, order_id);
            err_cnt++;
          end
          if (order_kind !== want.kind) begin
            $error("order_kind: expected %0d, got %0d", want.kind, order_kind);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        trigger_on_item(cmd, price);
      end
    end
    orders_due <= pending_orders.size();
    mismatches <= err_cnt;
  end

endmodule

@@ bench/windowed_momentum_order_trigger_tb.sv @@
`timescale 1ns / 1ps
// windowed_momentum_order_trigger_tb: stimulus and verdict for the order trigger
// uses wmot_pkg, windowed_momentum_order_trigger and wmot_order_checker

module windowed_momentum_order_trigger_tb;

  localparam int RANDOM_ITEMS = 900;
  localparam int QUIET_FROM   = 780;
  localparam int CYCLE_LIMIT  = 300000;

  localparam logic [wmot_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [wmot_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic [wmot_pkg::CFG_IDX_W-1:0] idx;
    logic [wmot_pkg::WORD_W-1:0]    data;
  } reg_write_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic                           cmd;
  logic [wmot_pkg::WORD_W-1:0]    price;
  logic                           out_valid;
  logic                           out_stall;
  logic                           order_side;
  logic [wmot_pkg::WORD_W-1:0]    order_qty;
  logic [wmot_pkg::ID_W-1:0]      order_id;
  logic                           order_kind;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [wmot_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wmot_pkg::WORD_W-1:0]    cfg_data;
  int unsigned                    orders_due;
  int unsigned                    mismatches;

  reg_write_t                  cfg_plan[$];
  logic [wmot_pkg::WORD_W-1:0] cur_period;
  bit                          stall_enable;
  int unsigned                 items_done;
  int unsigned                 cycle_cnt = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  windowed_momentum_order_trigger u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .price(price),
    .out_valid(out_valid), .out_stall(out_stall),
    .order_side(order_side), .order_qty(order_qty),
    .order_id(order_id), .order_kind(order_kind),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  wmot_order_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .price(price),
    .out_valid(out_valid), .out_stall(out_stall),
    .order_side(order_side), .order_qty(order_qty),
    .order_id(order_id), .order_kind(order_kind),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .orders_due(orders_due), .mismatches(mismatches)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver back-pressure in bursts
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_enable && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  // valid stays high across back-to-back transfers
  task automatic send_item(input wmot_pkg::cmd_t c, input logic [wmot_pkg::WORD_W-1:0] p);
    int unsigned gap;
    gap = 0;
    if (stall_enable && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    price    <= p;
    do @(posedge clk); while (in_stall);
  endtask

  // let the pipe empty, including items that make no order
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (orders_due != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic queue_write(input logic [wmot_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wmot_pkg::WORD_W-1:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    cfg_plan.insert(cfg_plan.size(), w);
  endtask

  task automatic apply_cfg_plan();
    reg_write_t w;
    while (cfg_plan.size() != 0) begin
      w = cfg_plan[0];
      cfg_plan.delete(0);
      if (w.idx == wmot_pkg::CFG_PROBE_PERIOD) cur_period = w.data;
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.data;
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [wmot_pkg::WORD_W-1:0] pick_word(input int unsigned span);
    case ($urandom_range(0, 7))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return $urandom_range(0, span);
      default:    return $urandom;
    endcase
  endfunction

  // upper bits random, only the low bits count
  function automatic logic [wmot_pkg::WORD_W-1:0] lookback_word();
    logic [wmot_pkg::WORD_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0:       w[wmot_pkg::LOOKBACK_W-1:0] = 7'd0;
      1:       w[wmot_pkg::LOOKBACK_W-1:0] = 7'd1;
      2:       w[wmot_pkg::LOOKBACK_W-1:0] = 7'd64;
      3:       w[wmot_pkg::LOOKBACK_W-1:0] = 7'($urandom_range(65, 126));
      4:       w[wmot_pkg::LOOKBACK_W-1:0] = 7'd127;
      default: w[wmot_pkg::LOOKBACK_W-1:0] = 7'($urandom_range(2, 16));
    endcase
    return w;
  endfunction

  initial begin
    logic [wmot_pkg::WORD_W-1:0] walk_price;
    logic [wmot_pkg::WORD_W-1:0] p;
    int unsigned                 n;
    int unsigned                 tick_odds;
    bit                          noisy;

    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = wmot_pkg::CMD_TRADE;
    price        = '0;
    cfg_valid    = 1'b0;
    cfg_index    = wmot_pkg::CFG_LOOKBACK_LEN;
    cfg_data     = '0;
    stall_enable = 1'b1;
    items_done   = 0;
    cur_period   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // two-price window, equal move, full-range moves, probes both sides
    queue_write(wmot_pkg::CFG_LOOKBACK_LEN, 32'd2);
    queue_write(wmot_pkg::CFG_MOVE_THRESHOLD, 32'd10);
    queue_write(wmot_pkg::CFG_TRADE_ORDER_SIZE, 32'hFFFF_FFFF);
    queue_write(wmot_pkg::CFG_PROBE_PERIOD, 32'd3);
    queue_write(wmot_pkg::CFG_PROBE_ORDER_SIZE, 32'd7);
    queue_write(wmot_pkg::CFG_CLIENT_ID, 32'hFFFF_FFFF);
    queue_write(CFG_SPARE_LO, $urandom);
    queue_write(CFG_SPARE_HI, $urandom);
    apply_cfg_plan();
    send_item(wmot_pkg::CMD_TRADE, 32'd100);
    send_item(wmot_pkg::CMD_TRADE, 32'd111);
    send_item(wmot_pkg::CMD_TRADE, 32'd101);
    send_item(wmot_pkg::CMD_TRADE, 32'd90);
    send_item(wmot_pkg::CMD_TRADE, 32'd0);
    send_item(wmot_pkg::CMD_TRADE, 32'hFFFF_FFFF);
    send_item(wmot_pkg::CMD_TRADE, 32'd0);
    repeat (7) send_item(wmot_pkg::CMD_TICK, $urandom);

    // trading and probing both off
    settle();
    queue_write(wmot_pkg::CFG_LOOKBACK_LEN, 32'hFFFF_FF80);
    queue_write(wmot_pkg::CFG_PROBE_PERIOD, 32'd0);
    queue_write(wmot_pkg::CFG_MOVE_THRESHOLD, 32'd0);
    apply_cfg_plan();
    send_item(wmot_pkg::CMD_TRADE, 32'd5);
    send_item(wmot_pkg::CMD_TRADE, 32'd900);
    send_item(wmot_pkg::CMD_TICK, $urandom);
    send_item(wmot_pkg::CMD_TICK, $urandom);

    // lookback grown, period rewritten restarts the tick phase
    settle();
    queue_write(wmot_pkg::CFG_LOOKBACK_LEN, 32'd3);
    queue_write(wmot_pkg::CFG_MOVE_THRESHOLD, 32'd5);
    queue_write(wmot_pkg::CFG_TRADE_ORDER_SIZE, 32'd0);
    queue_write(wmot_pkg::CFG_PROBE_PERIOD, 32'd3);
    queue_write(wmot_pkg::CFG_PROBE_ORDER_SIZE, 32'hFFFF_FFFF);
    queue_write(wmot_pkg::CFG_CLIENT_ID, 32'd0);
    apply_cfg_plan();
    send_item(wmot_pkg::CMD_TRADE, 32'd50);
    send_item(wmot_pkg::CMD_TRADE, 32'd20);
    send_item(wmot_pkg::CMD_TRADE, 32'd80);
    repeat (3) send_item(wmot_pkg::CMD_TICK, $urandom);

    while (items_done < RANDOM_ITEMS) begin
      settle();
      stall_enable = (items_done < QUIET_FROM);
      if ($urandom_range(0, 1)) queue_write(wmot_pkg::CFG_LOOKBACK_LEN, lookback_word());
      if ($urandom_range(0, 1)) queue_write(wmot_pkg::CFG_MOVE_THRESHOLD, pick_word(60));
      if ($urandom_range(0, 1)) queue_write(wmot_pkg::CFG_TRADE_ORDER_SIZE, pick_word(1000));
      if ($urandom_range(0, 1)) queue_write(wmot_pkg::CFG_PROBE_PERIOD, pick_word(8));
      if ($urandom_range(0, 1)) queue_write(wmot_pkg::CFG_PROBE_ORDER_SIZE, pick_word(1000));
      if ($urandom_range(0, 2) == 0) queue_write(wmot_pkg::CFG_CLIENT_ID, pick_word(20));
      if ($urandom_range(0, 9) == 0) queue_write(CFG_SPARE_HI, $urandom);
      apply_cfg_plan();

      noisy      = ($urandom_range(0, 4) == 0);
      tick_odds  = $urandom_range(0, 4);
      walk_price = $urandom;
      n          = $urandom_range(20, 80);
      repeat (n) begin
        if ($urandom_range(0, 9) < tick_odds) begin
          send_item(wmot_pkg::CMD_TICK, $urandom);
          if (cur_period != 0) items_done++;
        end else begin
          if (noisy) begin
            p = $urandom;
          end else begin
            // mostly a random walk so moves land near the threshold
            case ($urandom_range(0, 19))
              0:       p = '0;
              1:       p = '1;
              2:       p = $urandom;
              default: p = walk_price + $urandom_range(0, 80) - 40;
            endcase
            walk_price = p;
          end
          send_item(wmot_pkg::CMD_TRADE, p);
          items_done++;
        end
      end
    end

    settle();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
